[src/gbn_pkg.sv]
// gbn_pkg: shared codes, widths, reset values and the result record
// for the go-back-n sender window unit
// no dependencies
package gbn_pkg;

	// sequence space limit used as the default parameter value
	localparam int MAX_SEQ_DEF = 32;

	// field and register widths
	localparam int REQ_W     = 2;
	localparam int BYTE_W    = 8;
	localparam int SEQB_W    = 6;
	localparam int PKT_W     = 16;
	localparam int SEQ_CNT_W = 6;
	localparam int WIN_W     = 5;
	localparam int TMO_W     = 6;
	localparam int IDLE_W    = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 6;
	localparam int PHASE_W   = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_START      = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POLL_EMPTY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POLL_BYTE  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_RSVD       = 2'd3;

	// handshake accept byte from the receiver
	localparam logic [BYTE_W-1:0] ACCEPT_CODE = 8'd200;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

	// configuration reset values
	localparam logic [SEQ_CNT_W-1:0] SEQ_COUNT_RST = 6'd20;
	localparam logic [WIN_W-1:0]     WINDOW_RST    = 5'd10;
	localparam logic [TMO_W-1:0]     TIMEOUT_RST   = 6'd20;

	// one result item
	typedef struct packed {
		logic              send_ready;
		logic              send_frame;
		logic [SEQB_W-1:0] frame_seq_byte;
		logic [PKT_W-1:0]  frame_packet_index;
		logic              ack_taken;
		logic              timed_out;
		logic              handshake_failed;
		logic [PHASE_W-1:0] phase_now;
	} result_t;

endpackage

[src/go_back_n_sender_window_unit.sv]
// go_back_n_sender_window_unit: go-back-n sender window control, one event per item
// depends on gbn_pkg
// the result is registered at the edge that accepts the item, into the result register or the skid
// throughput: one item per cycle while the skid is empty and no settle window runs; a two-entry
// output (result register plus skid) keeps input accepting while one result waits
// after reset and after any configuration write, in_ready stays low while the clamped
// limits register and the pointers are re-reduced
// reset: asynchronous, clears phase, pointers, counters, free map to all ones
module go_back_n_sender_window_unit import gbn_pkg::*; #(
	parameter int MAX_SEQ = MAX_SEQ_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	// input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [BYTE_W-1:0]    rx_byte,
	// output channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 send_ready,
	output logic                 send_frame,
	output logic [SEQB_W-1:0]    frame_seq_byte,
	output logic [PKT_W-1:0]     frame_packet_index,
	output logic                 ack_taken,
	output logic                 timed_out,
	output logic                 handshake_failed,
	output logic [PHASE_W-1:0]   phase_now
);

	localparam int SW = (MAX_SEQ > 2) ? $clog2(MAX_SEQ) : 1;
	localparam int NW = $clog2(MAX_SEQ + 1);
	localparam int CW = (NW > SEQ_CNT_W) ? NW : SEQ_CNT_W;
	localparam int WW = (NW > WIN_W) ? NW : WIN_W;
	localparam int AW = (NW > BYTE_W) ? NW : BYTE_W;
	localparam int RW = SW + NW;
	localparam int HOLD_W = 2;
	localparam logic [HOLD_W-1:0] HOLD_CYC = 2'd3;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_XFER = 2'd2
	} phase_t;

	// reduce a pointer modulo the sequence count by restoring subtraction
	function automatic logic [SW-1:0] mod_n(input logic [SW-1:0] x, input logic [NW-1:0] n);
		logic [RW-1:0] r;
		logic [RW-1:0] dv;
		r = RW'(x);
		for (int k = SW - 1; k >= 0; k--) begin
			dv = RW'(n) << k;
			if (r >= dv) begin
				r = r - dv;
			end
		end
		return SW'(r);
	endfunction

	// configuration and derived limits
	logic [SEQ_CNT_W-1:0] seq_count_q;
	logic [WIN_W-1:0]     window_q;
	logic [TMO_W-1:0]     timeout_q;
	logic [NW-1:0]        n_q;
	logic [NW-1:0]        w_q;
	logic [HOLD_W-1:0]    hold_q;

	// window state
	phase_t               phase_q;
	logic [SW-1:0]        next_q;
	logic [SW-1:0]        base_q;
	logic [SW-1:0]        red_next_q;
	logic [SW-1:0]        red_base_q;
	logic [PKT_W-1:0]     pkt_q;
	logic [IDLE_W-1:0]    idle_q;
	logic [MAX_SEQ-1:0]   free_q;

	// output register and skid
	result_t              res_q;
	result_t              skid_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;

	logic                 accept;
	logic                 take;

	// clamped limits
	logic [CW-1:0]        sc_ext;
	logic [NW-1:0]        n_clamp;
	logic [WW-1:0]        w_ext;
	logic [WW-1:0]        w_top;
	logic [NW-1:0]        w_clamp;

	// send decision
	logic [SW-1:0]        cur_next;
	logic [SW-1:0]        cur_base;
	logic [NW-1:0]        outst0;
	logic [NW-1:0]        outst1;
	logic                 can_send;
	logic [SW-1:0]        next1;
	logic [PKT_W-1:0]     pkt1;
	logic [MAX_SEQ-1:0]   free1;

	// ack decode
	logic [BYTE_W-1:0]    ack_seq;
	logic [SW-1:0]        ack_s;
	logic                 ack_in_n;
	logic [NW-1:0]        ack_d;
	logic                 ack_ok;
	logic [SW-1:0]        base_new;

	// rewind and ack ranges over the free map
	logic [MAX_SEQ-1:0]   tmo_mask;
	logic [MAX_SEQ-1:0]   ack_mask;

	// next state
	phase_t               nx_phase;
	logic [IDLE_W-1:0]    nx_idle;
	logic [SW-1:0]        nx_next;
	logic [SW-1:0]        nx_base;
	logic [SW-1:0]        nx_red_next;
	logic [SW-1:0]        nx_red_base;
	logic [PKT_W-1:0]     nx_pkt;
	logic [MAX_SEQ-1:0]   nx_free;
	result_t              nx_res;

	// handshakes
	assign take     = out_valid_q & out_ready;
	assign in_ready = ~skid_valid_q & (hold_q == '0);
	assign accept   = in_valid & in_ready;

	// clamp sequence count to 2..MAX_SEQ and window to 1..n-1
	always_comb begin
		sc_ext = CW'(seq_count_q);
		if (sc_ext < CW'(2)) begin
			n_clamp = NW'(2);
		end else if (sc_ext > CW'(MAX_SEQ)) begin
			n_clamp = NW'(MAX_SEQ);
		end else begin
			n_clamp = NW'(sc_ext);
		end
		w_ext = WW'(window_q);
		w_top = WW'(n_q) - WW'(1);
		if (w_ext < WW'(1)) begin
			w_clamp = NW'(1);
		end else if (w_ext > w_top) begin
			w_clamp = NW'(w_top);
		end else begin
			w_clamp = NW'(w_ext);
		end
	end

	// frame send check at the front of a transfer poll
	always_comb begin
		cur_next = red_next_q;
		cur_base = red_base_q;
		if (cur_next >= cur_base) begin
			outst0 = NW'(cur_next) - NW'(cur_base);
		end else begin
			outst0 = NW'(cur_next) + n_q - NW'(cur_base);
		end
		can_send = (outst0 < w_q) && free_q[cur_next];
		outst1   = can_send ? outst0 + NW'(1) : outst0;
		if (!can_send) begin
			next1 = cur_next;
		end else if (NW'(cur_next) + NW'(1) == n_q) begin
			next1 = '0;
		end else begin
			next1 = cur_next + SW'(1);
		end
		pkt1  = can_send ? pkt_q + PKT_W'(1) : pkt_q;
		free1 = free_q;
		if (can_send) begin
			free1[cur_next] = 1'b0;
		end
	end

	// cumulative ack: received byte minus one, only inside the outstanding range
	always_comb begin
		ack_seq  = rx_byte - BYTE_W'(1);
		ack_in_n = AW'(ack_seq) < AW'(n_q);
		ack_s    = SW'(ack_seq);
		if (ack_s >= cur_base) begin
			ack_d = NW'(ack_s) - NW'(cur_base);
		end else begin
			ack_d = NW'(ack_s) + n_q - NW'(cur_base);
		end
		ack_ok = ack_in_n && (ack_d < outst1);
		if (NW'(ack_s) + NW'(1) == n_q) begin
			base_new = '0;
		end else begin
			base_new = ack_s + SW'(1);
		end
	end

	// per-entry offset from the window base, checked against both ranges
	always_comb begin
		logic [NW:0] off;
		for (int j = 0; j < MAX_SEQ; j++) begin
			if ((NW+1)'(j) >= (NW+1)'(cur_base)) begin
				off = (NW+1)'(j) - (NW+1)'(cur_base);
			end else begin
				off = (NW+1)'(j) + (NW+1)'(n_q) - (NW+1)'(cur_base);
			end
			tmo_mask[j] = ((NW+1)'(j) < (NW+1)'(n_q)) && (off < (NW+1)'(outst1));
			ack_mask[j] = ((NW+1)'(j) < (NW+1)'(n_q)) && (off <= (NW+1)'(ack_d));
		end
	end

	// event handling for one item
	always_comb begin
		nx_phase    = phase_q;
		nx_idle     = idle_q;
		nx_next     = next_q;
		nx_base     = base_q;
		nx_red_next = red_next_q;
		nx_red_base = red_base_q;
		nx_pkt      = pkt_q;
		nx_free     = free_q;
		nx_res      = '0;
		if (req_type == REQ_START) begin
			nx_res.send_ready = 1'b1;
			nx_phase = PH_WAIT;
			nx_idle  = '0;
		end else if (req_type != REQ_RSVD && phase_q == PH_WAIT) begin
			if (req_type == REQ_POLL_EMPTY) begin
				if (idle_q >= timeout_q) begin
					nx_res.handshake_failed = 1'b1;
					nx_idle  = '0;
					nx_phase = PH_IDLE;
				end else begin
					nx_idle = idle_q + IDLE_W'(1);
				end
			end else if (rx_byte == ACCEPT_CODE) begin
				nx_next     = '0;
				nx_base     = '0;
				nx_red_next = '0;
				nx_red_base = '0;
				nx_pkt      = '0;
				nx_idle     = '0;
				nx_free     = '1;
				nx_phase    = PH_XFER;
			end
		end else if (req_type != REQ_RSVD && phase_q == PH_XFER) begin
			nx_res.send_frame         = can_send;
			nx_res.frame_seq_byte     = can_send ? SEQB_W'((NW+1)'(cur_next) + (NW+1)'(1)) : '0;
			nx_res.frame_packet_index = can_send ? pkt_q : '0;
			nx_free = free1;
			nx_next = next1;
			nx_base = cur_base;
			nx_pkt  = pkt1;
			if (req_type == REQ_POLL_EMPTY) begin
				if (idle_q >= timeout_q) begin
					// go back: free the outstanding entries and rewind the packet index
					nx_res.timed_out = 1'b1;
					nx_free = free1 | tmo_mask;
					nx_pkt  = pkt1 - PKT_W'(outst1);
					nx_next = cur_base;
					nx_idle = '0;
				end else begin
					nx_idle = idle_q + IDLE_W'(1);
				end
			end else begin
				nx_idle = '0;
				if (ack_ok) begin
					nx_res.ack_taken = 1'b1;
					nx_free = free1 | ack_mask;
					nx_base = base_new;
				end
			end
			nx_red_next = nx_next;
			nx_red_base = nx_base;
		end
		nx_res.phase_now = nx_phase;
	end

	// state, configuration and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_count_q  <= SEQ_COUNT_RST;
			window_q     <= WINDOW_RST;
			timeout_q    <= TIMEOUT_RST;
			n_q          <= NW'(2);
			w_q          <= NW'(1);
			hold_q       <= HOLD_CYC;
			phase_q      <= PH_IDLE;
			next_q       <= '0;
			base_q       <= '0;
			red_next_q   <= '0;
			red_base_q   <= '0;
			pkt_q        <= '0;
			idle_q       <= '0;
			free_q       <= '1;
			res_q        <= '0;
			skid_q       <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			// configuration writes and settle window
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SEQ_COUNT: seq_count_q <= cfg_wdata[SEQ_CNT_W-1:0];
					CFG_WINDOW:    window_q    <= cfg_wdata[WIN_W-1:0];
					CFG_TIMEOUT:   timeout_q   <= cfg_wdata[TMO_W-1:0];
					default: ;
				endcase
				hold_q <= HOLD_CYC;
			end else if (hold_q != '0) begin
				hold_q <= hold_q - HOLD_W'(1);
			end
			n_q <= n_clamp;
			w_q <= w_clamp;

			// window state
			if (accept) begin
				phase_q    <= nx_phase;
				next_q     <= nx_next;
				base_q     <= nx_base;
				red_next_q <= nx_red_next;
				red_base_q <= nx_red_base;
				pkt_q      <= nx_pkt;
				idle_q     <= nx_idle;
				free_q     <= nx_free;
			end else begin
				red_next_q <= mod_n(next_q, n_q);
				red_base_q <= mod_n(base_q, n_q);
			end

			// result register with skid entry
			if (accept) begin
				if (!out_valid_q || take) begin
					res_q       <= nx_res;
					out_valid_q <= 1'b1;
				end else begin
					skid_q       <= nx_res;
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				if (skid_valid_q) begin
					res_q        <= skid_q;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// output ports
	assign out_valid          = out_valid_q;
	assign send_ready         = res_q.send_ready;
	assign send_frame         = res_q.send_frame;
	assign frame_seq_byte     = res_q.frame_seq_byte;
	assign frame_packet_index = res_q.frame_packet_index;
	assign ack_taken          = res_q.ack_taken;
	assign timed_out          = res_q.timed_out;
	assign handshake_failed   = res_q.handshake_failed;
	assign phase_now          = res_q.phase_now;

	// a waiting skid entry always sits behind a valid result
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a result in front");

	// once settled, working pointers are inside the sequence space
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q == '0) |-> (NW'(red_next_q) < n_q) && (NW'(red_base_q) < n_q))
		else $error("window pointer outside the sequence space");

	// an ack and a rewind come from different poll kinds
	a_ack_xor_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.ack_taken && res_q.timed_out))
		else $error("ack and timeout reported by one item");

	// frames only go out while transferring
	a_frame_in_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.send_frame) |-> (res_q.phase_now == PH_XFER))
		else $error("frame sent outside transfer");

endmodule

[tb/go_back_n_sender_window_unit_tb.sv]
// go_back_n_sender_window_unit_tb: self-checking bench for the go-back-n sender window unit
// holds a result scoreboard class with its own window predictor, drivers and the run sequence
// depends on gbn_pkg and go_back_n_sender_window_unit
module go_back_n_sender_window_unit_tb import gbn_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASE_COUNT  = 6;
	localparam int PHASE_ITEMS  = 305;
	localparam int HOLD_AT      = 100;
	localparam int PAUSE_AT     = 200;
	localparam int WARM_ITEMS   = 60;

	// protocol phases as reported on phase_now
	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_XFER = 2'd2
	} phase_t;

	// expected results and the window state that produces them
	class window_scoreboard_t;
		logic [SEQ_CNT_W-1:0]   seq_reg;
		logic [WIN_W-1:0]       win_reg;
		logic [TMO_W-1:0]       tmo_reg;
		logic [MAX_SEQ_DEF-1:0] free_map;
		int                     next_seq;
		int                     base_seq;
		int                     idle_polls;
		logic [PKT_W-1:0]       pkt_count;
		phase_t                 ph;
		result_t                results_due[$];
		int                     mismatches;

		function new();
			seq_reg    = SEQ_COUNT_RST;
			win_reg    = WINDOW_RST;
			tmo_reg    = TIMEOUT_RST;
			free_map   = '1;
			next_seq   = 0;
			base_seq   = 0;
			idle_polls = 0;
			pkt_count  = '0;
			ph         = PH_IDLE;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				CFG_SEQ_COUNT: seq_reg = data[SEQ_CNT_W-1:0];
				CFG_WINDOW:    win_reg = data[WIN_W-1:0];
				CFG_TIMEOUT:   tmo_reg = data[TMO_W-1:0];
				default: ;
			endcase
		endfunction

		// sequence space after clamping
		function int seq_mod();
			int n;
			n = seq_reg;
			if (n < 2) n = 2;
			if (n > MAX_SEQ_DEF) n = MAX_SEQ_DEF;
			return n;
		endfunction

		function int outstanding();
			int n;
			n = seq_mod();
			return ((next_seq % n) + n - (base_seq % n)) % n;
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		// work out the result of one accepted request
		function void note_request(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] rx);
			result_t r;
			int n, w, outst, a, d, i;
			n = seq_mod();
			w = win_reg;
			if (w < 1) w = 1;
			if (w > n - 1) w = n - 1;
			r = '0;
			if (req == REQ_START) begin
				r.send_ready = 1'b1;
				ph = PH_WAIT;
				idle_polls = 0;
			end else if (req != REQ_RSVD && ph == PH_WAIT) begin
				if (req == REQ_POLL_EMPTY) begin
					if (idle_polls >= tmo_reg) begin
						r.handshake_failed = 1'b1;
						idle_polls = 0;
						ph = PH_IDLE;
					end else begin
						idle_polls++;
					end
				end else if (rx == ACCEPT_CODE) begin
					next_seq = 0;
					base_seq = 0;
					pkt_count = '0;
					idle_polls = 0;
					free_map = '1;
					ph = PH_XFER;
				end
			end else if (req != REQ_RSVD && ph == PH_XFER) begin
				next_seq = next_seq % n;
				base_seq = base_seq % n;
				outst = (next_seq + n - base_seq) % n;
				// one frame per poll when the window and the slot allow
				if (outst < w && free_map[next_seq]) begin
					r.send_frame = 1'b1;
					r.frame_seq_byte = SEQB_W'(next_seq + 1);
					r.frame_packet_index = pkt_count;
					free_map[next_seq] = 1'b0;
					next_seq = (next_seq + 1) % n;
					pkt_count = pkt_count + 1'b1;
					outst++;
				end
				if (req == REQ_POLL_EMPTY) begin
					// go back to the window base on timeout
					if (idle_polls >= tmo_reg) begin
						r.timed_out = 1'b1;
						for (i = 0; i < outst; i++) free_map[(base_seq + i) % n] = 1'b1;
						pkt_count = pkt_count - PKT_W'(outst);
						next_seq = base_seq;
						idle_polls = 0;
					end else begin
						idle_polls++;
					end
				end else begin
					// cumulative ack, ignored outside the outstanding range
					a = (int'(rx) + 255) % 256;
					idle_polls = 0;
					if (a < n) begin
						d = (a + n - base_seq) % n;
						if (d < outst) begin
							for (i = 0; i <= d; i++) free_map[(base_seq + i) % n] = 1'b1;
							base_seq = (a + 1) % n;
							r.ack_taken = 1'b1;
						end
					end
				end
			end
			r.phase_now = ph;
			results_due.push_back(r);
		endfunction

		function void cmp(string fld, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d actual %0d", $time, fld, want, got);
				mismatches++;
			end
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(result_t got);
			result_t want;
			if (results_due.size() == 0) begin
				$display("%0t: result item with nothing expected, expected none actual %h",
					$time, got);
				mismatches++;
				return;
			end
			want = results_due.pop_front();
			cmp("send_ready", want.send_ready, got.send_ready);
			cmp("send_frame", want.send_frame, got.send_frame);
			cmp("frame_seq_byte", want.frame_seq_byte, got.frame_seq_byte);
			cmp("frame_packet_index", want.frame_packet_index, got.frame_packet_index);
			cmp("ack_taken", want.ack_taken, got.ack_taken);
			cmp("timed_out", want.timed_out, got.timed_out);
			cmp("handshake_failed", want.handshake_failed, got.handshake_failed);
			cmp("phase_now", want.phase_now, got.phase_now);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic [REQ_W-1:0]     req_type;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic                 send_ready;
	logic                 send_frame;
	logic [SEQB_W-1:0]    frame_seq_byte;
	logic [PKT_W-1:0]     frame_packet_index;
	logic                 ack_taken;
	logic                 timed_out;
	logic                 handshake_failed;
	logic [PHASE_W-1:0]   phase_now;

	window_scoreboard_t sb;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	int burst_left;

	// register settings per random phase: seq_count, window_size, timeout_polls
	logic [CFG_DAT_W-1:0] phase_regs [PHASE_COUNT][3] = '{
		'{6'd32, 6'd31, 6'd40},
		'{6'd0,  6'd0,  6'd1},
		'{6'd5,  6'd31, 6'd3},
		'{6'd1,  6'd1,  6'd0},
		'{6'd17, 6'd8,  6'd63},
		'{6'd63, 6'd12, 6'd6}
	};

	go_back_n_sender_window_unit i_dut (
		.clk, .arst_n,
		.cfg_we, .cfg_index, .cfg_wdata,
		.in_valid, .in_ready, .req_type, .rx_byte,
		.out_valid, .out_ready,
		.send_ready, .send_frame, .frame_seq_byte, .frame_packet_index,
		.ack_taken, .timed_out, .handshake_failed, .phase_now
	);

	// clock
	always #5 clk = ~clk;

	// offer one request item and wait for it to be taken
	task automatic send_item(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] rx);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		rx_byte  <= rx;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req, rx);
	endtask

	// stop offering and wait until every expected result has come
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() > 0);
	endtask

	// write all three registers on consecutive cycles
	task automatic program_regs(input logic [CFG_DAT_W-1:0] sc, wz, tm);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [CFG_DAT_W-1:0] val [3];
		int k;
		idx[0] = CFG_SEQ_COUNT;
		idx[1] = CFG_WINDOW;
		idx[2] = CFG_TIMEOUT;
		val[0] = sc;
		val[1] = wz;
		val[2] = tm;
		for (k = 0; k < 3; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[k];
			cfg_wdata <= val[k];
			sb.write_reg(idx[k], val[k]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// choose the next request from the predicted protocol phase
	function automatic void pick_item(input bit allow_start,
			output logic [REQ_W-1:0] req, output logic [BYTE_W-1:0] rx);
		int roll, n, outst;
		n = sb.seq_mod();
		outst = sb.outstanding();
		roll = $urandom_range(99);
		rx = BYTE_W'($urandom);
		req = REQ_POLL_BYTE;
		if (burst_left > 0) begin
			burst_left--;
			req = REQ_POLL_EMPTY;
		end else if (sb.ph == PH_IDLE) begin
			if (roll < 85) req = REQ_START;
			else if (roll < 93) req = REQ_POLL_EMPTY;
			else if (roll < 97) req = REQ_POLL_BYTE;
			else req = REQ_RSVD;
		end else if (sb.ph == PH_WAIT) begin
			if (roll < 60) begin
				rx = ACCEPT_CODE;
			end else if (roll < 75) begin
				req = REQ_POLL_EMPTY;
			end else if (roll < 80) begin
				// run of empty polls long enough to abandon the handshake
				burst_left = sb.tmo_reg;
				req = REQ_POLL_EMPTY;
			end else if (roll >= 96) begin
				req = REQ_RSVD;
			end else if (roll >= 92) begin
				req = REQ_START;
			end
		end else begin
			if (roll < 55 || (roll >= 88 && roll < 92 && !allow_start)) begin
				// ack somewhere inside the outstanding range
				if (outst > 0) rx = BYTE_W'((sb.base_seq % n + $urandom_range(outst - 1)) % n + 1);
				else rx = BYTE_W'($urandom_range(n + 1, 1));
			end else if (roll < 72) begin
				req = REQ_POLL_EMPTY;
			end else if (roll < 76) begin
				burst_left = sb.tmo_reg;
				req = REQ_POLL_EMPTY;
			end else if (roll < 88) begin
				req = REQ_POLL_BYTE;
			end else if (roll < 92) begin
				req = REQ_START;
			end else if (roll < 95) begin
				req = REQ_RSVD;
			end else begin
				rx = BYTE_W'($urandom_range(n + 1, 1));
			end
		end
	endfunction

	// result side: random stalls, long hold-off on request, checking
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result({send_ready, send_frame, frame_seq_byte, frame_packet_index,
					ack_taken, timed_out, handshake_failed, phase_now});
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// run limit
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	// stimulus sequence
	initial begin
		logic [REQ_W-1:0]  req;
		logic [BYTE_W-1:0] rx;
		int p, count;
		bit ignored;
		sb = new();
		send_idle_pct = 19;
		recv_idle_pct = 78;
		hold_cycles = 0;
		burst_left = 0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_SEQ_COUNT;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		req_type  <= REQ_START;
		rx_byte   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: smallest sequence space, window clamped up, no empty polls tolerated
		program_regs(6'd2, 6'd0, 6'd0);
		send_item(REQ_POLL_EMPTY, 8'd0);
		send_item(REQ_RSVD, 8'd255);
		send_item(REQ_START, 8'd0);
		send_item(REQ_POLL_BYTE, 8'd17);
		send_item(REQ_POLL_EMPTY, 8'd0);
		send_item(REQ_START, 8'd0);
		send_item(REQ_POLL_BYTE, ACCEPT_CODE);
		send_item(REQ_POLL_BYTE, 8'd1);
		send_item(REQ_POLL_BYTE, 8'd255);
		drain_results();

		// widen the sequence space mid-transfer so the rewind takes the packet index below zero
		program_regs(6'd63, 6'd31, 6'd0);
		send_item(REQ_POLL_EMPTY, 8'd0);
		send_item(REQ_POLL_BYTE, 8'd0);
		send_item(REQ_POLL_BYTE, 8'd2);
		send_item(REQ_POLL_EMPTY, 8'd0);
		send_item(REQ_START, 8'd0);
		send_item(REQ_POLL_BYTE, ACCEPT_CODE);
		send_item(REQ_POLL_BYTE, 8'd200);
		send_item(REQ_START, 8'd0);
		send_item(REQ_POLL_EMPTY, 8'd0);
		drain_results();

		// random phases; early in the first one, transfer polls that would restart become acks
		for (p = 0; p < PHASE_COUNT; p++) begin
			if (p < 2) begin
				send_idle_pct = 19;
				recv_idle_pct = 78;
			end else if (p < 4) begin
				send_idle_pct = 78;
				recv_idle_pct = 19;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 0) program_regs(phase_regs[p][0], phase_regs[p][1], 6'd40);
			else program_regs(phase_regs[p][0], phase_regs[p][1], phase_regs[p][2]);
			burst_left = 0;
			count = 0;
			while (count < PHASE_ITEMS) begin
				pick_item(!(p == 0 && count < WARM_ITEMS), req, rx);
				ignored = (req == REQ_RSVD) || (req != REQ_START && sb.ph == PH_IDLE);
				send_item(req, rx);
				if (!ignored) begin
					count++;
					// receiver backs up long enough to stall the input
					if (count == HOLD_AT) hold_cycles = 60;
					if (count == PAUSE_AT) drain_results();
				end
			end
			drain_results();
		end

		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[files.f]
src/gbn_pkg.sv
src/go_back_n_sender_window_unit.sv
tb/go_back_n_sender_window_unit_tb.sv
